@@ design/rcpi_pkg.sv @@
// Shared types and constants for the ray / convex polyhedron intercept unit.
package rcpi_pkg;

    localparam int MAX_FACES_DEF = 16;
    localparam int FRAC_BITS_DEF = 16;

    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_FACE_COUNT = 3'd0;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_RAY   = 1'b1;

    localparam logic signed [31:0] T_NEG_INF = 32'sh8000_0000;
    localparam logic signed [31:0] T_POS_INF = 32'sh7FFF_FFFF;
    localparam logic signed [4:0]  SURF_NONE = -5'sd1;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
    } plane_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec3_t;

endpackage

@@ design/rcpi_req_if.sv @@
// Request and result channel interfaces.
interface rcpi_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [3:0]         face_index;
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic signed [31:0] coef_d;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;

    modport source (output valid, req_type, face_index, coef_a, coef_b, coef_c, coef_d,
                    start_x, start_y, start_z, dir_x, dir_y, dir_z, input ready);
    modport sink (input valid, req_type, face_index, coef_a, coef_b, coef_c, coef_d,
                  start_x, start_y, start_z, dir_x, dir_y, dir_z, output ready);
endinterface

interface rcpi_res_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] dist_in;
    logic signed [31:0] dist_out;
    logic signed [4:0]  surf_in;
    logic signed [4:0]  surf_out;

    modport source (output valid, hit, dist_in, dist_out, surf_in, surf_out, input ready);
    modport sink (input valid, hit, dist_in, dist_out, surf_in, surf_out, output ready);
endinterface

@@ design/rcpi_face_cell.sv @@
// One face slot of the rotating plane ring.
module rcpi_face_cell
    import rcpi_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   shift_en,
    input  logic   wr_en,
    input  plane_t wr_plane,
    input  plane_t nb_plane,
    input  logic   nb_valid,
    output plane_t plane,
    output logic   valid
);

    plane_t plane_reg;
    logic   valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            valid_reg <= 1'b1;
        end
        else if (shift_en)
        begin
            valid_reg <= nb_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            plane_reg <= wr_plane;
        end
        else if (shift_en)
        begin
            plane_reg <= nb_plane;
        end
    end

    assign plane = plane_reg;
    assign valid = valid_reg;

endmodule

@@ design/rcpi_div.sv @@
// Restoring divider, one quotient bit per cycle: (num << FRAC_BITS) / den.
module rcpi_div
    import rcpi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [31:0] quo,
    output logic        ovf
);

    localparam int DW = 64 + FRAC_BITS;
    localparam int IW = $clog2(DW);

    logic [DW-1:0] dvd_reg;
    logic [63:0]   rem_reg;
    logic [63:0]   den_reg;
    logic [31:0]   quo_reg;
    logic          ovf_reg;
    logic [IW-1:0] idx_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [64:0] trial;
    logic [64:0] diff;
    logic        ge;

    assign trial = {rem_reg, dvd_reg[DW-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && idx_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {num, {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
            idx_reg <= IW'(DW - 1);
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
            rem_reg <= ge ? diff[63:0] : trial[63:0];
            // quotient bits at weight 2^32 and above only flag overflow
            if (idx_reg < IW'(32))
            begin
                quo_reg <= {quo_reg[30:0], ge};
            end
            else
            begin
                ovf_reg <= ovf_reg | ge;
            end
            idx_reg <= idx_reg - IW'(1);
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign ovf  = ovf_reg;

endmodule

@@ design/ray_convex_polyhedron_intercept_unit.sv @@
// Top level: face ring, face sequencer, dot-product datapath and result register.
//
// The face table is a ring of MAX_FACES cells that rotates one slot per face
// step, so the head cell always presents face i to a single shared datapath;
// each ray rotates the ring a full turn, leaving it aligned for writes. Every
// tested valid face runs six 32x32 products through one registered multiplier,
// then magnitude and check steps and, unless the face is parallel, the
// one-bit-per-cycle divider, which sets the rate. The result waits in an output
// register, so new writes and rays are taken while it is not yet collected.
module ray_convex_polyhedron_intercept_unit
    import rcpi_pkg::*;
#(
    parameter int MAX_FACES = MAX_FACES_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    rcpi_req_if.sink           req,
    rcpi_res_if.source         res
);

    localparam int CW = $clog2(MAX_FACES + 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_FACE   = 7'b0000010,
        S_MUL    = 7'b0000100,
        S_SIGN   = 7'b0001000,
        S_CHK    = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [4:0] face_count_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr == ADDR_FACE_COUNT) ? {27'd0, face_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_count_reg <= 5'd0;
        end
        else if (cfg_wr && paddr == ADDR_FACE_COUNT)
        begin
            face_count_reg <= pwdata[4:0];
        end
    end

    // face ring
    plane_t cell_plane [MAX_FACES];
    logic   cell_valid [MAX_FACES];
    logic   rotate;
    logic   req_acc;
    plane_t wr_plane;

    assign req_acc  = req.valid && req.ready;
    assign wr_plane = '{a: req.coef_a, b: req.coef_b, c: req.coef_c, d: req.coef_d};

    for (genvar j = 0; j < MAX_FACES; j++)
    begin : g_ring
        rcpi_face_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (rotate),
            .wr_en    (req_acc && req.req_type == REQ_WRITE && 32'(req.face_index) == j),
            .wr_plane (wr_plane),
            .nb_plane (cell_plane[(j + 1) % MAX_FACES]),
            .nb_valid (cell_valid[(j + 1) % MAX_FACES]),
            .plane    (cell_plane[j]),
            .valid    (cell_valid[j])
        );
    end

    // ray state
    vec3_t              org_reg, dir_reg;
    logic [CW-1:0]      fi_reg;
    logic [2:0]         step_reg;
    logic               miss_reg;
    logic signed [31:0] tnear_reg, tfar_reg;
    logic signed [4:0]  snear_reg, sfar_reg;
    logic signed [63:0] prod_reg;
    logic signed [66:0] vd_reg, vn_reg;
    logic               dneg_reg, nneg_reg;
    logic [63:0]        dm_reg, nm_reg;
    logic [31:0]        n_faces;
    logic               face_live;
    logic [31:0]        fi_ext;
    logic signed [4:0]  fi_surf;

    assign n_faces   = (32'(face_count_reg) > 32'(MAX_FACES)) ? 32'(MAX_FACES)
                                                              : 32'(face_count_reg);
    assign fi_ext    = 32'(fi_reg);
    assign fi_surf   = fi_ext[4:0];
    assign face_live = !miss_reg && fi_ext < n_faces && cell_valid[0];

    // one product a cycle
    logic signed [31:0] mul_a, mul_b;
    always_comb
    begin
        case (step_reg)
            3'd0:    begin mul_a = cell_plane[0].a; mul_b = dir_reg.x; end
            3'd1:    begin mul_a = cell_plane[0].b; mul_b = dir_reg.y; end
            3'd2:    begin mul_a = cell_plane[0].c; mul_b = dir_reg.z; end
            3'd3:    begin mul_a = cell_plane[0].a; mul_b = org_reg.x; end
            3'd4:    begin mul_a = cell_plane[0].b; mul_b = org_reg.y; end
            3'd5:    begin mul_a = cell_plane[0].c; mul_b = org_reg.z; end
            default: begin mul_a = 32'sd0;          mul_b = 32'sd0;    end
        endcase
    end

    logic signed [66:0] prod_ext, d_term;
    assign prod_ext = {{3{prod_reg[63]}}, prod_reg};
    assign d_term   = {{(35 - FRAC_BITS){cell_plane[0].d[31]}}, cell_plane[0].d,
                       {FRAC_BITS{1'b0}}};

    // divider
    logic        div_start, div_done, div_ovf;
    logic [31:0] div_quo;

    assign div_start = (state_reg == S_CHK) && dm_reg != 64'd0;

    rcpi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (nm_reg),
        .den   (dm_reg),
        .done  (div_done),
        .quo   (div_quo),
        .ovf   (div_ovf)
    );

    // saturated signed distance from the quotient
    logic signed [31:0] t_val;
    always_comb
    begin
        if (nm_reg != 64'd0 && nneg_reg == dneg_reg)
        begin
            t_val = (div_ovf || div_quo > 32'h8000_0000) ? T_NEG_INF : -$signed(div_quo);
        end
        else
        begin
            t_val = (div_ovf || div_quo[31]) ? T_POS_INF : $signed(div_quo);
        end
    end

    // result register
    logic              res_valid_reg, res_hit_reg;
    logic signed [31:0] res_in_reg, res_out_reg;
    logic signed [4:0] res_sin_reg, res_sout_reg;
    logic              res_load;
    logic              hit_c;
    logic signed [4:0] sin_c, sout_c;

    assign res_load = (state_reg == S_FINISH) && (!res_valid_reg || res.ready);

    always_comb
    begin
        hit_c  = 1'b0;
        sin_c  = SURF_NONE;
        sout_c = SURF_NONE;
        if (!miss_reg)
        begin
            if (tnear_reg > 32'sd0)
            begin
                if (tnear_reg < tfar_reg)
                begin
                    hit_c  = 1'b1;
                    sin_c  = snear_reg;
                    sout_c = sfar_reg;
                end
            end
            else if (tfar_reg > 32'sd0)
            begin
                hit_c  = 1'b1;
                sout_c = sfar_reg;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        rotate     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_acc && req.req_type == REQ_RAY)
                begin
                    state_next = S_FACE;
                end
            end
            S_FACE:
            begin
                if (fi_ext == 32'(MAX_FACES))
                begin
                    state_next = S_FINISH;
                end
                else if (face_live)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    rotate = 1'b1;
                end
            end
            S_MUL:
            begin
                if (step_reg == 3'd6)
                begin
                    state_next = S_SIGN;
                end
            end
            S_SIGN:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (dm_reg == 64'd0)
                begin
                    rotate     = 1'b1;
                    state_next = S_FACE;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    rotate     = 1'b1;
                    state_next = S_FACE;
                end
            end
            S_FINISH:
            begin
                if (res_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req.ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fi_reg        <= '0;
            step_reg      <= 3'd0;
            miss_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (rotate)
            begin
                fi_reg <= fi_reg + CW'(1);
            end
            if (state_reg == S_IDLE)
            begin
                fi_reg   <= '0;
                miss_reg <= 1'b0;
            end
            if (state_reg == S_MUL)
            begin
                step_reg <= step_reg + 3'd1;
            end
            else
            begin
                step_reg <= 3'd0;
            end
            // parallel face with origin outside
            if (state_reg == S_CHK && dm_reg == 64'd0 && !nneg_reg && nm_reg != 64'd0)
            begin
                miss_reg <= 1'b1;
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            org_reg   <= '{x: req.start_x, y: req.start_y, z: req.start_z};
            dir_reg   <= '{x: req.dir_x, y: req.dir_y, z: req.dir_z};
            tnear_reg <= T_NEG_INF;
            tfar_reg  <= T_POS_INF;
            snear_reg <= SURF_NONE;
            sfar_reg  <= SURF_NONE;
        end
        prod_reg <= mul_a * mul_b;
        if (state_reg == S_MUL)
        begin
            if (step_reg == 3'd0)
            begin
                vd_reg <= '0;
                vn_reg <= d_term;
            end
            else if (step_reg < 3'd4)
            begin
                vd_reg <= vd_reg + prod_ext;
            end
            else
            begin
                vn_reg <= vn_reg + prod_ext;
            end
        end
        if (state_reg == S_SIGN)
        begin
            dneg_reg <= vd_reg[66];
            nneg_reg <= vn_reg[66];
            dm_reg   <= vd_reg[66] ? 64'(-vd_reg) : vd_reg[63:0];
            nm_reg   <= vn_reg[66] ? 64'(-vn_reg) : vn_reg[63:0];
        end
        if (state_reg == S_DIV && div_done)
        begin
            if (dneg_reg)
            begin
                if (t_val > tnear_reg)
                begin
                    tnear_reg <= t_val;
                    snear_reg <= fi_surf;
                end
            end
            else if (t_val < tfar_reg)
            begin
                tfar_reg <= t_val;
                sfar_reg <= fi_surf;
            end
        end
        if (res_load)
        begin
            res_hit_reg  <= hit_c;
            res_in_reg   <= tnear_reg;
            res_out_reg  <= tfar_reg;
            res_sin_reg  <= sin_c;
            res_sout_reg <= sout_c;
        end
    end

    assign res.valid    = res_valid_reg;
    assign res.hit      = res_hit_reg;
    assign res.dist_in  = res_in_reg;
    assign res.dist_out = res_out_reg;
    assign res.surf_in  = res_sin_reg;
    assign res.surf_out = res_sout_reg;

    a_fi_range: assert property (@(posedge clk) disable iff (!rst_n)
        fi_ext <= 32'(MAX_FACES))
        else $error("face counter past table end");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> dm_reg != 64'd0 && state_next == S_DIV)
        else $error("divider started on zero divisor");

    a_ring_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> fi_reg == '0 || $past(state_reg) == S_FINISH)
        else $error("ring left unaligned after ray");

    a_res_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!res_valid_reg || res.ready))
        else $error("result overwritten before collection");

endmodule
